[hdl/dzrs_pkg.sv]
// shared types, constants and register indexes for the daily zone run sequencer
// used by every module under hdl; no dependencies
package dzrs_pkg;

  localparam int MAX_ZONES     = 8;
  localparam int DEFAULT_ZONES = 4;
  localparam int ZONE_W        = 4;
  localparam int MIN_W         = 8;

  localparam logic [7:0] HOUR_LIMIT   = 8'd23;
  localparam logic [7:0] HOUR_DEFAULT = 8'd6;
  localparam logic [7:0] MINUTE_LIMIT = 8'd59;
  localparam logic [7:0] MINUTES_MAX  = 8'd240;
  localparam logic [7:0] MASK_DAYS    = 8'h7F;
  localparam logic [5:0] SECOND_LIMIT = 6'd2;

  localparam logic [63:0] DURATIONS_RESET = 64'h0101_0101_0101_0101;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_HOUR      = 3'd1,
    REG_MINUTE    = 3'd2,
    REG_DAY_MASK  = 3'd3,
    REG_ZONES     = 3'd4,
    REG_DURATIONS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                              enable;
    logic [7:0]                        hour;
    logic [7:0]                        minute;
    logic [7:0]                        mask;
    logic [ZONE_W-1:0]                 count;
    logic [MAX_ZONES-1:0][MIN_W-1:0]   minutes;
  } cfg_t;

  typedef struct packed {
    logic       clk_ok;
    logic [2:0] weekday;
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [9:0] year_now;
    logic [8:0] day_of_year;
    logic       zone_busy;
  } tick_t;

  typedef struct packed {
    logic              start_valid;
    logic [ZONE_W-1:0] start_zone;
    logic [MIN_W-1:0]  start_minutes;
    logic              run_in_progress;
    logic              run_done;
    logic [ZONE_W-1:0] upcoming_zone;
  } res_t;

endpackage

[hdl/dzrs_cfg.sv]
// configuration registers with clamping applied on the way out
// depends on dzrs_pkg
module dzrs_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output dzrs_pkg::cfg_t      cfg,
  output logic                clr
);

  logic        enable;
  logic [7:0]  hour_reg;
  logic [7:0]  minute_reg;
  logic [7:0]  weekday_mask;
  logic [7:0]  zones_in_use;
  logic [63:0] zone_durations;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      hour_reg       <= dzrs_pkg::HOUR_DEFAULT;
      minute_reg     <= 8'd0;
      weekday_mask   <= dzrs_pkg::MASK_DAYS;
      zones_in_use   <= 8'(dzrs_pkg::DEFAULT_ZONES);
      zone_durations <= dzrs_pkg::DURATIONS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dzrs_pkg::REG_ENABLE:    enable         <= cfg_data[0];
        dzrs_pkg::REG_HOUR:      hour_reg       <= cfg_data[7:0];
        dzrs_pkg::REG_MINUTE:    minute_reg     <= cfg_data[7:0];
        dzrs_pkg::REG_DAY_MASK:  weekday_mask   <= cfg_data[7:0];
        dzrs_pkg::REG_ZONES:     zones_in_use   <= cfg_data[7:0];
        dzrs_pkg::REG_DURATIONS: zone_durations <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      dzrs_pkg::REG_ENABLE, dzrs_pkg::REG_HOUR, dzrs_pkg::REG_MINUTE,
      dzrs_pkg::REG_DAY_MASK, dzrs_pkg::REG_ZONES, dzrs_pkg::REG_DURATIONS:
        clr = cfg_we;
      default: clr = 1'b0;
    endcase
  end

  always_comb begin
    logic [7:0] m;
    cfg.enable = enable;
    cfg.hour   = (hour_reg > dzrs_pkg::HOUR_LIMIT) ? dzrs_pkg::HOUR_DEFAULT : hour_reg;
    cfg.minute = (minute_reg > dzrs_pkg::MINUTE_LIMIT) ? 8'd0 : minute_reg;
    cfg.mask   = weekday_mask & dzrs_pkg::MASK_DAYS;
    if (zones_in_use == 8'd0) begin
      cfg.count = dzrs_pkg::ZONE_W'(dzrs_pkg::DEFAULT_ZONES);
    end else if (zones_in_use > 8'(dzrs_pkg::MAX_ZONES)) begin
      cfg.count = dzrs_pkg::ZONE_W'(dzrs_pkg::MAX_ZONES);
    end else begin
      cfg.count = zones_in_use[dzrs_pkg::ZONE_W-1:0];
    end
    for (int i = 0; i < dzrs_pkg::MAX_ZONES; i++) begin
      m = zone_durations[i*8 +: 8];
      if (m == 8'd0) begin
        cfg.minutes[i] = 8'd1;
      end else if (m > dzrs_pkg::MINUTES_MAX) begin
        cfg.minutes[i] = dzrs_pkg::MINUTES_MAX;
      end else begin
        cfg.minutes[i] = m;
      end
    end
  end

endmodule

[hdl/dzrs_core.sv]
// run state, daily trigger match and zone sequencing for one tick
// depends on dzrs_pkg; result is combinational, state updates on accept
module dzrs_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                clr,
  input  logic                accept,
  input  dzrs_pkg::cfg_t      cfg,
  input  dzrs_pkg::tick_t     tick,
  output dzrs_pkg::res_t      res
);

  logic                        running, running_next;
  logic [dzrs_pkg::ZONE_W-1:0] next_index, next_index_next;
  logic                        trigger_seen, trigger_seen_next;
  logic [9:0]                  trigger_year, trigger_year_next;
  logic [8:0]                  trigger_day, trigger_day_next;

  logic go;
  logic same_day;
  logic hit;

  assign go       = cfg.enable & tick.clk_ok;
  assign same_day = trigger_seen && (trigger_year == tick.year_now) &&
                    (trigger_day == tick.day_of_year);
  assign hit      = cfg.mask[tick.weekday] && ({3'b000, tick.hour_now} == cfg.hour) &&
                    ({2'b00, tick.minute_now} == cfg.minute) &&
                    (tick.second_now <= dzrs_pkg::SECOND_LIMIT) && !same_day;

  always_comb begin
    running_next      = running;
    next_index_next   = next_index;
    trigger_seen_next = trigger_seen;
    trigger_year_next = trigger_year;
    trigger_day_next  = trigger_day;
    res.start_valid   = 1'b0;
    res.start_zone    = '0;
    res.start_minutes = '0;
    res.run_done      = 1'b0;
    if (go) begin
      if (running) begin
        if (!tick.zone_busy) begin
          if (next_index < cfg.count) begin
            res.start_valid   = 1'b1;
            res.start_zone    = next_index + 1'b1;
            res.start_minutes = cfg.minutes[next_index[2:0]];
            next_index_next   = next_index + 1'b1;
          end else begin
            running_next    = 1'b0;
            next_index_next = '0;
            res.run_done    = 1'b1;
          end
        end
      end else if (hit) begin
        trigger_seen_next = 1'b1;
        trigger_year_next = tick.year_now;
        trigger_day_next  = tick.day_of_year;
        running_next      = 1'b1;
        res.start_valid   = 1'b1;
        res.start_zone    = dzrs_pkg::ZONE_W'(1);
        res.start_minutes = cfg.minutes[0];
        next_index_next   = dzrs_pkg::ZONE_W'(1);
      end
    end
    res.run_in_progress = running_next;
    res.upcoming_zone   = (running_next && next_index_next < cfg.count) ?
                          next_index_next + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      running      <= 1'b0;
      next_index   <= '0;
      trigger_seen <= 1'b0;
      trigger_year <= '0;
      trigger_day  <= '0;
    end else if (accept) begin
      running      <= running_next;
      next_index   <= next_index_next;
      trigger_seen <= trigger_seen_next;
      trigger_year <= trigger_year_next;
      trigger_day  <= trigger_day_next;
    end
  end

  // a started zone is always numbered from one and has nonzero minutes
  a_start_zone: assert property (@(posedge clk) disable iff (rst)
    res.start_valid |-> (res.start_zone != '0 && res.start_minutes != '0))
    else $error("zone start without zone number or minutes");

  // completion ends the run
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.run_done |-> (!res.run_in_progress && !res.start_valid))
    else $error("run done while run still active");

  // a write to a defined register index drops the run and the trigger record
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clr |=> (!running && !trigger_seen && next_index == '0))
    else $error("state not cleared after register write");

  // an active run has started at least its first zone
  a_index: assert property (@(posedge clk) disable iff (rst)
    running |-> (next_index != '0 && next_index <= dzrs_pkg::ZONE_W'(dzrs_pkg::MAX_ZONES)))
    else $error("zone index out of range in active run");

endmodule

[hdl/daily_zone_run_sequencer.sv]
// daily zone run sequencer: an accepted tick's result beat is registered, offered in the next cycle
// throughput one tick per cycle while m_tready keeps the output register draining; it refills on the cycle it drains
// one result beat per tick; set by the single compare and select path into the output register
// rst (synchronous) restores register defaults, clears the run and trigger record
// and empties the output register
// depends on dzrs_pkg, dzrs_cfg, dzrs_core
module daily_zone_run_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // weekday, hour_now, minute_now, second_now, year_now, day_of_year, zone_busy
  input  logic [39:0] s_tdata,
  // clk_ok
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // start_zone, start_minutes, run_in_progress, upcoming_zone, zero fill
  output logic [23:0] m_tdata,
  // start_valid
  output logic        m_tuser,
  // run_done
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dzrs_pkg::cfg_t  cfg;
  dzrs_pkg::tick_t tick;
  dzrs_pkg::res_t  res;
  dzrs_pkg::res_t  res_q;
  logic            clr;
  logic            accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign tick.clk_ok      = s_tuser;
  assign tick.weekday     = s_tdata[2:0];
  assign tick.hour_now    = s_tdata[7:3];
  assign tick.minute_now  = s_tdata[13:8];
  assign tick.second_now  = s_tdata[19:14];
  assign tick.year_now    = s_tdata[29:20];
  assign tick.day_of_year = s_tdata[38:30];
  assign tick.zone_busy   = s_tdata[39];

  dzrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clr       (clr)
  );

  dzrs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .clr    (clr),
    .accept (accept),
    .cfg    (cfg),
    .tick   (tick),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tdata = {7'b0, res_q.upcoming_zone, res_q.run_in_progress,
                    res_q.start_minutes, res_q.start_zone};
  assign m_tuser = res_q.start_valid;
  assign m_tlast = res_q.run_done;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench for daily_zone_run_sequencer: directed table of ticks and register writes,
// then randomized phases checked beat by beat against a cycle-free prediction of the schedule
// depends on dzrs_pkg and the rtl under hdl
module testbench;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 125;

  typedef struct {
    bit              is_reg;
    logic [2:0]      reg_index;
    logic [63:0]     reg_value;
    dzrs_pkg::tick_t tk;
    bit              typed;
    dzrs_pkg::res_t  want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // register copy and run state as the sequencer should hold them
  logic        sched_enable = 1'b0;
  logic [7:0]  sched_hour = 8'd6;
  logic [7:0]  sched_minute = 8'd0;
  logic [7:0]  sched_mask = 8'h7F;
  logic [7:0]  sched_zones = 8'd4;
  logic [63:0] sched_minutes = dzrs_pkg::DURATIONS_RESET;
  bit          run_on = 1'b0;
  int          zones_started = 0;
  bit          date_held = 1'b0;
  logic [9:0]  held_year = '0;
  logic [8:0]  held_day = '0;

  dzrs_pkg::res_t expected_beats[$];
  step_t          plan[$];
  int    n_errors = 0, n_ticks = 0, n_beats = 0, n_starts = 0, n_runs = 0, n_writes = 0;
  bit    calm = 1'b0, hold_req = 1'b0, typed_now = 1'b0;
  dzrs_pkg::res_t typed_want = '0;

  daily_zone_run_sequencer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int zones_configured();
    if (sched_zones == 0) return dzrs_pkg::DEFAULT_ZONES;
    if (sched_zones > dzrs_pkg::MAX_ZONES) return dzrs_pkg::MAX_ZONES;
    return int'(sched_zones);
  endfunction

  function automatic logic [7:0] zone_run_minutes(int idx);
    logic [7:0] m;
    m = sched_minutes[idx*8 +: 8];
    if (m == 0) return 8'd1;
    if (m > dzrs_pkg::MINUTES_MAX) return dzrs_pkg::MINUTES_MAX;
    return m;
  endfunction

  function automatic dzrs_pkg::res_t predict_tick(dzrs_pkg::tick_t t);
    dzrs_pkg::res_t r;
    int cnt;
    logic [7:0] hh, mm, days;
    r = '0;
    cnt = zones_configured();
    if (sched_enable && t.clk_ok) begin
      if (run_on) begin
        if (!t.zone_busy) begin
          if (zones_started < cnt) begin
            r.start_valid = 1'b1;
            r.start_zone = 4'(zones_started + 1);
            r.start_minutes = zone_run_minutes(zones_started);
            zones_started++;
          end else begin
            run_on = 1'b0;
            zones_started = 0;
            r.run_done = 1'b1;
          end
        end
      end else begin
        hh = (sched_hour > dzrs_pkg::HOUR_LIMIT) ? dzrs_pkg::HOUR_DEFAULT : sched_hour;
        mm = (sched_minute > dzrs_pkg::MINUTE_LIMIT) ? 8'd0 : sched_minute;
        days = sched_mask & dzrs_pkg::MASK_DAYS;
        if (days[t.weekday] && {3'b0, t.hour_now} == hh && {2'b0, t.minute_now} == mm &&
            t.second_now <= dzrs_pkg::SECOND_LIMIT &&
            !(date_held && held_year == t.year_now && held_day == t.day_of_year)) begin
          date_held = 1'b1;
          held_year = t.year_now;
          held_day = t.day_of_year;
          run_on = 1'b1;
          r.start_valid = 1'b1;
          r.start_zone = 4'd1;
          r.start_minutes = zone_run_minutes(0);
          zones_started = 1;
        end
      end
    end
    r.run_in_progress = run_on;
    r.upcoming_zone = (run_on && zones_started < cnt) ? 4'(zones_started + 1) : 4'd0;
    return r;
  endfunction

  function automatic void take_register(logic [2:0] idx, logic [63:0] v);
    case (idx)
      dzrs_pkg::REG_ENABLE:    sched_enable = v[0];
      dzrs_pkg::REG_HOUR:      sched_hour = v[7:0];
      dzrs_pkg::REG_MINUTE:    sched_minute = v[7:0];
      dzrs_pkg::REG_DAY_MASK:  sched_mask = v[7:0];
      dzrs_pkg::REG_ZONES:     sched_zones = v[7:0];
      dzrs_pkg::REG_DURATIONS: sched_minutes = v;
      default:                 return;
    endcase
    run_on = 1'b0;
    zones_started = 0;
    date_held = 1'b0;
    held_year = '0;
    held_day = '0;
  endfunction

  function automatic dzrs_pkg::tick_t make_tick(int v, int wd, int hh, int mm, int ss, int yy,
                                                int dd, int b);
    dzrs_pkg::tick_t t;
    t.clk_ok = v[0];
    t.weekday = wd[2:0];
    t.hour_now = hh[4:0];
    t.minute_now = mm[5:0];
    t.second_now = ss[5:0];
    t.year_now = yy[9:0];
    t.day_of_year = dd[8:0];
    t.zone_busy = b[0];
    return t;
  endfunction

  function automatic dzrs_pkg::res_t make_res(int sv, int zone, int mins, int rip, int done,
                                              int up);
    dzrs_pkg::res_t r;
    r.start_valid = sv[0];
    r.start_zone = zone[3:0];
    r.start_minutes = mins[7:0];
    r.run_in_progress = rip[0];
    r.run_done = done[0];
    r.upcoming_zone = up[3:0];
    return r;
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [63:0] v);
    step_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.reg_index = idx;
    s.reg_value = v;
    plan.push_back(s);
  endfunction

  function automatic void plan_tick(dzrs_pkg::tick_t t, bit typed, dzrs_pkg::res_t want);
    step_t s;
    s = '{default: '0};
    s.tk = t;
    s.typed = typed;
    s.want = want;
    plan.push_back(s);
  endfunction

  function automatic logic [7:0] pick_time_reg(int limit);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return limit[7:0];
      2: return 8'($urandom_range(limit + 1, 255));
      default: return 8'($urandom_range(0, limit));
    endcase
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic send_tick(dzrs_pkg::tick_t t, bit typed, dzrs_pkg::res_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {t.zone_busy, t.day_of_year, t.year_now, t.second_now, t.minute_now,
                t.hour_now, t.weekday};
    s_tuser <= t.clk_ok;
    typed_now = typed;
    typed_want = want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_ticks++;
    @(negedge clk);
  endtask

  // registers change only once every result is out
  task automatic write_register(logic [2:0] idx, logic [63:0] v);
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    take_register(idx, v);
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    dzrs_pkg::tick_t seen;
    dzrs_pkg::res_t  got;
    if (!rst && s_tvalid && s_tready) begin
      seen.clk_ok = s_tuser;
      seen.weekday = s_tdata[2:0];
      seen.hour_now = s_tdata[7:3];
      seen.minute_now = s_tdata[13:8];
      seen.second_now = s_tdata[19:14];
      seen.year_now = s_tdata[29:20];
      seen.day_of_year = s_tdata[38:30];
      seen.zone_busy = s_tdata[39];
      got = predict_tick(seen);
      expected_beats.push_back(typed_now ? typed_want : got);
    end
  end

  always @(posedge clk) begin
    dzrs_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_beats++;
      if (m_tuser) n_starts++;
      if (m_tlast) n_runs++;
      if (expected_beats.size() == 0) begin
        n_errors++;
        $error("result beat with no tick waiting for it");
      end else begin
        want = expected_beats.pop_front();
        compare_field("start_valid", int'(want.start_valid), int'(m_tuser));
        compare_field("start_zone", int'(want.start_zone), int'(m_tdata[3:0]));
        compare_field("start_minutes", int'(want.start_minutes), int'(m_tdata[11:4]));
        compare_field("run_in_progress", int'(want.run_in_progress), int'(m_tdata[12]));
        compare_field("run_done", int'(want.run_done), int'(m_tlast));
        compare_field("upcoming_zone", int'(want.upcoming_zone), int'(m_tdata[16:13]));
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int goal, wd, follow, yy, dd, hh, mm;
    logic [63:0] dur;
    logic [7:0] days;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled after reset
    plan_tick(make_tick(1, 1, 6, 0, 0, 124, 10, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_reg(dzrs_pkg::REG_ENABLE, 64'd1);
    // clock invalid, weekday 7, out-of-range clock, late second
    plan_tick(make_tick(0, 1, 6, 0, 0, 124, 10, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_tick(make_tick(1, 7, 6, 0, 0, 124, 10, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_tick(make_tick(1, 1, 31, 63, 63, 0, 0, 1), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_tick(make_tick(1, 1, 6, 0, 3, 124, 10, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    // trigger while busy, then the default four-zone run
    plan_tick(make_tick(1, 6, 6, 0, 2, 1023, 511, 1), 1, make_res(1, 1, 1, 1, 0, 2));
    plan_tick(make_tick(1, 6, 6, 0, 2, 1023, 511, 1), 1, make_res(0, 0, 0, 1, 0, 2));
    plan_tick(make_tick(0, 6, 0, 0, 0, 1023, 511, 0), 1, make_res(0, 0, 0, 1, 0, 2));
    plan_tick(make_tick(1, 6, 6, 0, 10, 1023, 511, 0), 1, make_res(1, 2, 1, 1, 0, 3));
    plan_tick(make_tick(1, 6, 6, 0, 10, 1023, 511, 0), 1, make_res(1, 3, 1, 1, 0, 4));
    plan_tick(make_tick(1, 6, 6, 0, 10, 1023, 511, 0), 1, make_res(1, 4, 1, 1, 0, 0));
    plan_tick(make_tick(1, 6, 6, 0, 10, 1023, 511, 1), 1, make_res(0, 0, 0, 1, 0, 0));
    plan_tick(make_tick(1, 6, 6, 0, 10, 1023, 511, 0), 1, make_res(0, 0, 0, 0, 1, 0));
    // same day again, then a new day
    plan_tick(make_tick(1, 6, 6, 0, 0, 1023, 511, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_tick(make_tick(1, 0, 6, 0, 1, 0, 0, 0), 1, make_res(1, 1, 1, 1, 0, 2));
    // unused register index leaves the run alone
    plan_reg(REG_SPARE, '1);
    plan_tick(make_tick(1, 0, 6, 0, 5, 0, 0, 0), 1, make_res(1, 2, 1, 1, 0, 3));
    // clamped registers: hour and minute fall back, eight zones, minute limits
    plan_reg(dzrs_pkg::REG_DURATIONS, 64'hFF_F0_EF_80_02_01_00_F1);
    plan_reg(dzrs_pkg::REG_ZONES, 64'd255);
    plan_reg(dzrs_pkg::REG_HOUR, 64'd255);
    plan_reg(dzrs_pkg::REG_MINUTE, 64'd255);
    plan_reg(dzrs_pkg::REG_DAY_MASK, 64'h80);
    plan_tick(make_tick(1, 7, 6, 0, 0, 5, 5, 0), 1, make_res(0, 0, 0, 0, 0, 0));
    plan_reg(dzrs_pkg::REG_DAY_MASK, 64'hFF);
    plan_tick(make_tick(1, 0, 6, 0, 0, 5, 5, 1), 1, make_res(1, 1, 240, 1, 0, 2));
    plan_tick(make_tick(1, 0, 6, 0, 9, 5, 5, 0), 1, make_res(1, 2, 1, 1, 0, 3));
    repeat (7) plan_tick(make_tick(1, 0, 6, 0, 9, 5, 5, 0), 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_register(plan[i].reg_index, plan[i].reg_value);
      else send_tick(plan[i].tk, plan[i].typed, plan[i].want);
    end

    yy = 0;
    dd = 0;
    for (int p = 0; p < PHASES; p++) begin
      dur = '0;
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 5))
          0: dur[b*8 +: 8] = 8'd0;
          1: dur[b*8 +: 8] = dzrs_pkg::MINUTES_MAX;
          2: dur[b*8 +: 8] = 8'($urandom_range(241, 255));
          default: dur[b*8 +: 8] = 8'($urandom_range(1, 239));
        endcase
      end
      case (p)
        1: begin
          write_register(dzrs_pkg::REG_HOUR, 64'd0);
          write_register(dzrs_pkg::REG_MINUTE, 64'd0);
          write_register(dzrs_pkg::REG_ZONES, 64'd1);
          write_register(dzrs_pkg::REG_DURATIONS, 64'd0);
        end
        2: begin
          write_register(dzrs_pkg::REG_HOUR, 64'(dzrs_pkg::HOUR_LIMIT));
          write_register(dzrs_pkg::REG_MINUTE, 64'(dzrs_pkg::MINUTE_LIMIT));
          write_register(dzrs_pkg::REG_ZONES, 64'(dzrs_pkg::MAX_ZONES));
          write_register(dzrs_pkg::REG_DURATIONS, '1);
        end
        default: begin
          write_register(dzrs_pkg::REG_HOUR,
                         64'(pick_time_reg(int'(dzrs_pkg::HOUR_LIMIT))));
          write_register(dzrs_pkg::REG_MINUTE,
                         64'(pick_time_reg(int'(dzrs_pkg::MINUTE_LIMIT))));
          case ($urandom_range(0, 5))
            0: write_register(dzrs_pkg::REG_ZONES, 64'd0);
            1: write_register(dzrs_pkg::REG_ZONES, 64'd1);
            2: write_register(dzrs_pkg::REG_ZONES, 64'(dzrs_pkg::MAX_ZONES));
            3: write_register(dzrs_pkg::REG_ZONES,
                              64'($urandom_range(dzrs_pkg::MAX_ZONES + 1, 255)));
            default: write_register(dzrs_pkg::REG_ZONES,
                                    64'($urandom_range(1, dzrs_pkg::MAX_ZONES)));
          endcase
          write_register(dzrs_pkg::REG_DURATIONS, dur);
        end
      endcase
      case ($urandom_range(0, 4))
        0: write_register(dzrs_pkg::REG_DAY_MASK, 64'h80);
        1: write_register(dzrs_pkg::REG_DAY_MASK, 64'hFF);
        default: write_register(dzrs_pkg::REG_DAY_MASK, 64'($urandom_range(0, 255)));
      endcase
      write_register(dzrs_pkg::REG_ENABLE,
                     (p == 3) ? 64'd0 : 64'($urandom_range(0, 7) != 0));

      calm = ($urandom_range(0, 3) == 0);
      if (p == 4) hold_req = 1'b1;
      hh = int'((sched_hour > dzrs_pkg::HOUR_LIMIT) ? dzrs_pkg::HOUR_DEFAULT : sched_hour);
      mm = int'((sched_minute > dzrs_pkg::MINUTE_LIMIT) ? 8'd0 : sched_minute);
      days = sched_mask & dzrs_pkg::MASK_DAYS;
      goal = n_ticks + PHASE_TICKS;
      while (n_ticks < goal) begin
        if (days != 0 && $urandom_range(0, 7) != 0) begin
          do wd = $urandom_range(0, 6); while (!days[wd]);
        end else begin
          wd = $urandom_range(0, 7);
        end
        case ($urandom_range(0, 9))
          7: send_tick(make_tick($urandom_range(0, 1), wd, hh, mm, $urandom_range(0, 63),
                                 yy, dd, $urandom_range(0, 1)), 0, '0);
          8, 9: send_tick(make_tick($urandom_range(0, 1), $urandom_range(0, 7),
                                    $urandom_range(0, 31), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 1023),
                                    $urandom_range(0, 511), $urandom_range(0, 1)), 0, '0);
          default: begin
            // one day's run: trigger beat then zone ticks, sometimes on the previous date
            if ($urandom_range(0, 4) != 0) begin
              yy = $urandom_range(0, 1023);
              dd = $urandom_range(0, 365);
            end
            send_tick(make_tick(1, wd, hh, mm, $urandom_range(0, 2), yy, dd,
                                $urandom_range(0, 1)), 0, '0);
            follow = $urandom_range(2, 2 * zones_configured() + 6);
            repeat (follow)
              send_tick(make_tick(int'($urandom_range(0, 9) != 0), wd, hh, mm,
                                  $urandom_range(0, 60), yy, dd,
                                  int'($urandom_range(0, 2) == 0)), 0, '0);
          end
        endcase
      end
    end

    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d ticks and %0d result beats over %0d register writes",
             n_ticks, n_beats, n_writes);
    $display("zone starts seen: %0d, completed runs: %0d, mismatches: %0d",
             n_starts, n_runs, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
